FILE: rtl/swrms_pkg.sv
package swrms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RMS_W    = 16;
  localparam int WL_W     = 9;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [WL_W-1:0] WL_RESET = 9'd128;
  localparam logic [RMS_W-1:0] RMS_MAX = 16'hFFFF;

  localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  // Running sum of squares over at most 511 samples.
  function automatic int sum_w(input int sb);
    return 2 * sb + WL_W;
  endfunction

  function automatic int root_w(input int sb);
    return (sum_w(sb) + 1) / 2;
  endfunction

  // Divider/square-root operand, padded to an even bit count.
  function automatic int x_w(input int sb);
    return 2 * root_w(sb);
  endfunction

  typedef struct packed {
    logic capture;
    logic read;
    logic add;
    logic sub;
    logic div_step;
    logic sqrt_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_result;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/swrms_in_if.sv
interface swrms_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swrms_pkg::SAMPLE_W-1:0] sample;
  logic                                restart;

  modport source(output valid, output sample, output restart, input ready);
  modport sink(input valid, input sample, input restart, output ready);
endinterface

FILE: rtl/swrms_out_if.sv
interface swrms_out_if;
  logic                         valid;
  logic                         ready;
  logic [swrms_pkg::RMS_W-1:0]  rms;

  modport source(output valid, output rms, input ready);
  modport sink(input valid, input rms, output ready);
endinterface

FILE: rtl/swrms_ctrl.sv
module swrms_ctrl #(
  parameter int SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  swrms_pkg::status_t status,
  output swrms_pkg::cmd_t    cmd
);

  localparam int X_W    = swrms_pkg::x_w(SAMPLE_BITS);
  localparam int ROOT_W = swrms_pkg::root_w(SAMPLE_BITS);
  localparam int CNT_W  = $clog2(X_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_ADD  = 7'b0000100,
    ST_SUB  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_SQRT = 7'b0100000,
    ST_HOLD = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
        if (status.need_result) begin
          cnt_next   = CNT_W'(X_W - 1);
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          cnt_next   = CNT_W'(ROOT_W - 1);
          state_next = ST_SQRT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_HOLD;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_div_to_sqrt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == '0) |=> (state == ST_SQRT && cnt == CNT_W'(ROOT_W - 1)))
    else $error("divider did not hand over to square root");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a pending transaction");

endmodule

FILE: rtl/swrms_dp.sv
module swrms_dp #(
  parameter int MAX_WINDOW  = swrms_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_clear,
  input  logic [swrms_pkg::WL_W-1:0]           len,
  input  logic signed [swrms_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 restart,
  input  swrms_pkg::cmd_t                      cmd,
  output swrms_pkg::status_t                   status,
  output logic [swrms_pkg::RMS_W-1:0]          rms,
  output logic                                 out_valid,
  input  logic                                 out_ready
);

  localparam int WL_W   = swrms_pkg::WL_W;
  localparam int RMS_W  = swrms_pkg::RMS_W;
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CMP_W  = (PTR_W + 1 > WL_W) ? PTR_W + 1 : WL_W;
  localparam int EXT_W  = (SAMPLE_BITS > swrms_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : swrms_pkg::SAMPLE_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int SUM_W  = swrms_pkg::sum_w(SAMPLE_BITS);
  localparam int ROOT_W = swrms_pkg::root_w(SAMPLE_BITS);
  localparam int X_W    = swrms_pkg::x_w(SAMPLE_BITS);
  localparam int SAT_W  = (ROOT_W > RMS_W) ? ROOT_W : RMS_W;

  // window state
  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] old_raw;
  logic [SUM_W-1:0]       sum;
  logic [WL_W-1:0]        fill;
  logic [PTR_W-1:0]       ptr;
  logic [PTR_W-1:0]       slot;
  logic                   full;

  // arithmetic state
  logic [SQ_W-1:0]        sq;
  logic [X_W-1:0]         x;
  logic [WL_W-1:0]        rem;
  logic [ROOT_W:0]        srem;
  logic [ROOT_W-1:0]      root;

  logic [EXT_W-1:0]              sample_ext;
  logic [PTR_W-1:0]              slot_sel;
  logic [CMP_W-1:0]              slot_inc;
  logic signed [SAMPLE_BITS-1:0] mul_in;
  logic signed [SQ_W-1:0]        mul_out;
  logic [SUM_W-1:0]              sum_next;
  logic [WL_W-1:0]               fill_inc;
  logic [WL_W:0]                 div_r;
  logic                          div_ge;
  logic [ROOT_W+2:0]             sq_rs;
  logic [ROOT_W+2:0]             sq_trial;
  logic                          sq_ge;
  logic [SAT_W-1:0]              root_ext;

  assign sample_ext = EXT_W'($unsigned(sample));

  // a stale pointer past the window length restarts at slot zero
  assign slot_sel = (CMP_W'(ptr) >= CMP_W'(len)) ? '0 : ptr;
  assign slot_inc = CMP_W'(slot) + 1'b1;

  assign mul_in  = cmd.add ? $signed(old_raw) : $signed(raw);
  assign mul_out = mul_in * mul_in;

  assign sum_next = full ? sum - SUM_W'(sq) : sum;
  assign fill_inc = fill + 1'b1;

  assign status.need_result = full || (fill_inc >= len);
  assign status.out_free    = !out_valid || out_ready;

  assign div_r  = {rem, x[X_W-1]};
  assign div_ge = (div_r >= {1'b0, len});

  assign sq_rs    = {srem, x[X_W-1:X_W-2]};
  assign sq_trial = (ROOT_W+3)'({root, 2'b01});
  assign sq_ge    = (sq_rs >= sq_trial);

  assign root_ext = SAT_W'(root);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      old_raw   <= mem[slot_sel];
      mem[slot_sel] <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      fill <= '0;
      ptr  <= '0;
    end else if (cfg_clear || (cmd.capture && restart)) begin
      sum  <= '0;
      fill <= '0;
      ptr  <= '0;
    end else if (cmd.read) begin
      ptr <= slot_sel;
    end else if (cmd.add) begin
      sum <= sum + SUM_W'(sq);
    end else if (cmd.sub) begin
      sum <= sum_next;
      if (!full) begin
        fill <= fill_inc;
      end
      ptr <= (slot_inc >= CMP_W'(len)) ? '0 : PTR_W'(slot_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw <= sample_ext[SAMPLE_BITS-1:0];
    end
    if (cmd.read || cmd.add) begin
      sq <= $unsigned(mul_out);
    end
    if (cmd.read) begin
      slot <= slot_sel;
      full <= (fill >= len);
    end
    if (cmd.sub) begin
      x    <= X_W'(sum_next);
      rem  <= '0;
      srem <= '0;
      root <= '0;
    end else if (cmd.div_step) begin
      rem <= div_ge ? WL_W'(div_r - {1'b0, len}) : WL_W'(div_r);
      x   <= {x[X_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem <= sq_ge ? (ROOT_W+1)'(sq_rs - sq_trial) : sq_rs[ROOT_W:0];
      root <= {root[ROOT_W-2:0], sq_ge};
      x    <= {x[X_W-3:0], 2'b00};
    end
    if (cmd.load_out) begin
      rms <= (root_ext > SAT_W'(swrms_pkg::RMS_MAX)) ? swrms_pkg::RMS_MAX
                                                     : RMS_W'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= len)
    else $error("fill count beyond window length");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(ptr) < CMP_W'(len))
    else $error("write pointer beyond window length");

  a_restart_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && restart && !cfg_clear) |=> (fill == '0 && sum == '0 && ptr == '0))
    else $error("restart did not empty the window");

endmodule

FILE: rtl/sliding_window_true_rms_core.sv
// Sequence: capture, read, add, subtract; when a result is due, the sum is divided by the
//   window length and square-rooted, one quotient bit and one root bit per cycle.
// One sequencer runs both divide and root and holds the result until the output is free;
//   a new sample is taken only when idle. No result is due before the window fills.
// Reset: control, sum, fill count and pointer clear; window_length returns to 128.
//   The sample store is not cleared; an entry's old value is used only after it is written.
module sliding_window_true_rms_core #(
  parameter int MAX_WINDOW  = swrms_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  swrms_in_if.sink                          din,
  swrms_out_if.source                       dout,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swrms_pkg::PADDR_W-1:0]     paddr,
  input  logic [swrms_pkg::PDATA_W-1:0]     pwdata,
  output logic [swrms_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int WL_W = swrms_pkg::WL_W;
  localparam logic [WL_W-1:0] LEN_CAP = (MAX_WINDOW > (1 << WL_W) - 1)
                                        ? {WL_W{1'b1}} : WL_W'(MAX_WINDOW);

  logic [WL_W-1:0]               window_length;
  logic [WL_W-1:0]               len;
  logic                          reg_hit;
  logic                          cfg_write;
  swrms_pkg::cmd_t               cmd;
  swrms_pkg::status_t            status;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[swrms_pkg::PADDR_W-1:2] == swrms_pkg::REG_WINDOW_LENGTH);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? swrms_pkg::PDATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swrms_pkg::WL_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[WL_W-1:0];
    end
  end

  // clamp to the usable window range
  always_comb begin
    priority if (window_length == '0) begin
      len = WL_W'(1);
    end else if (window_length > LEN_CAP) begin
      len = LEN_CAP;
    end else begin
      len = window_length;
    end
  end

  swrms_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(din.valid),
    .in_ready(din.ready),
    .status  (status),
    .cmd     (cmd)
  );

  swrms_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_clear(cfg_write),
    .len      (len),
    .sample   (din.sample),
    .restart  (din.restart),
    .cmd      (cmd),
    .status   (status),
    .rms      (dout.rms),
    .out_valid(dout.valid),
    .out_ready(dout.ready)
  );

endmodule
